// ===== hw/rtl/pfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants of the page fifo
// Operation and status codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pfr_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int PAGE_BITS_DEF = 20;
	localparam int PAGE_W        = 20;
	localparam int KIND_W        = 2;
	localparam int STATUS_W      = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_TAKE   = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_TAKE_WAIT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load;       // capture the incoming beat
		logic    append;     // write key at tail, count up
		logic    rd_head;    // read the head entry
		logic    take;       // drop the head, count down
		logic    scan_start; // scan pointer to head, index to zero
		logic    rd_ptr;     // read the entry under the scan pointer
		logic    ptr_step;   // advance scan pointer and index
		logic    rd_next;    // read the entry after the scan pointer
		logic    shift_wr;   // move read entry down into pointer slot
		logic    remove;     // count down once the gap is closed
		logic    set_res;    // capture the pending result
		status_t res;
		logic    out_load;   // move pending result to the output
	} pfr_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  empty;
		logic  hit;
		logic  last;
		logic  out_free;
	} pfr_sts_t;

endpackage

// ===== hw/rtl/pfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_ctrl: operation sequencer
// Walks each operation through dispatch and then, by kind, head read or key
// scan and gap close, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module pfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pfr_pkg::pfr_sts_t sts,
	output pfr_pkg::pfr_cmd_t cmd
);
	import pfr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (sts.kind)
					KIND_TAKE:   state_d = sts.empty ? S_DONE : S_TAKE_WAIT;
					KIND_REMOVE: state_d = sts.empty ? S_DONE : S_SCAN_RD;
					default:     state_d = S_DONE;
				endcase
			end
			S_TAKE_WAIT: state_d = S_DONE;
			S_SCAN_RD:   state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				if (sts.hit) state_d = S_SHIFT_RD;
				else if (sts.last) state_d = S_DONE;
				else state_d = S_SCAN_RD;
			end
			S_SHIFT_RD: state_d = sts.last ? S_DONE : S_SHIFT_WR;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.res  = ST_OK;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_DISPATCH: begin
				case (sts.kind)
					KIND_APPEND: begin
						cmd.set_res = 1'b1;
						cmd.res     = sts.full ? ST_FULL : ST_OK;
						cmd.append  = !sts.full;
					end
					KIND_TAKE: begin
						cmd.rd_head = !sts.empty;
						cmd.set_res = sts.empty;
						cmd.res     = ST_EMPTY;
					end
					KIND_REMOVE: begin
						cmd.scan_start = !sts.empty;
						cmd.set_res    = sts.empty;
						cmd.res        = ST_NOT_FOUND;
					end
					default: begin
						cmd.set_res = 1'b1;
						cmd.res     = ST_OK;
					end
				endcase
			end
			S_TAKE_WAIT: begin
				cmd.take    = 1'b1;
				cmd.set_res = 1'b1;
				cmd.res     = ST_OK;
			end
			S_SCAN_RD: begin
				cmd.rd_ptr = 1'b1;
			end
			S_SCAN_CMP: begin
				if (!sts.hit) begin
					if (sts.last) begin
						cmd.set_res = 1'b1;
						cmd.res     = ST_NOT_FOUND;
					end else begin
						cmd.ptr_step = 1'b1;
					end
				end
			end
			S_SHIFT_RD: begin
				if (sts.last) begin
					cmd.remove  = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res     = ST_OK;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
			end
			S_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/pfr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_dp: page fifo datapath
// Circular entry memory with head and count, scan pointer and index,
// pending result and the output register.
// ----------------------------------------------------------------------------
module pfr_dp #(
	parameter int DEPTH     = pfr_pkg::DEPTH_DEF,
	parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pfr_pkg::KIND_W-1:0]    kind,
	input  logic [pfr_pkg::PAGE_W-1:0]    page,
	input  pfr_pkg::pfr_cmd_t             cmd,
	output pfr_pkg::pfr_sts_t             sts,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pfr_pkg::PAGE_W-1:0]    page_out,
	output logic [pfr_pkg::STATUS_W-1:0]  status,
	output logic                          is_empty
);
	import pfr_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = ADDR_W + 1;

	logic [PAGE_BITS-1:0] mem [DEPTH];
	logic [PAGE_BITS-1:0] rd_data_q;

	kind_t                kind_q;
	logic [PAGE_BITS-1:0] key_q;
	logic [ADDR_W-1:0]    head_q;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_W-1:0]    ptr_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [PAGE_W-1:0]    res_page_q;
	status_t              res_status_q;
	logic                 out_valid_q;
	logic [PAGE_W-1:0]    page_out_q;
	status_t              status_q;
	logic                 is_empty_q;

	logic [ADDR_W-1:0]    ptr_next;
	logic [ADDR_W-1:0]    head_next;
	logic [SUM_W-1:0]     tail_sum;
	logic [ADDR_W-1:0]    tail;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 rd_en;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [PAGE_BITS-1:0] wr_data;
	logic                 full;
	logic                 empty;

	assign ptr_next  = (ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : ptr_q + ADDR_W'(1);
	assign head_next = (head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + ADDR_W'(1);

	// tail slot wraps around the end of the ring
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
	                                              : ADDR_W'(tail_sum);

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign rd_en   = cmd.rd_head | cmd.rd_ptr | cmd.rd_next;
	assign rd_addr = cmd.rd_head ? head_q : (cmd.rd_ptr ? ptr_q : ptr_next);
	assign wr_en   = cmd.append | cmd.shift_wr;
	assign wr_addr = cmd.append ? tail : ptr_q;
	assign wr_data = cmd.append ? key_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			key_q  <= PAGE_BITS'(page);
		end
		if (cmd.scan_start) begin
			ptr_q <= head_q;
			idx_q <= '0;
		end else if (cmd.ptr_step || cmd.shift_wr) begin
			ptr_q <= ptr_next;
			idx_q <= idx_q + ADDR_W'(1);
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res;
			res_page_q   <= cmd.take ? PAGE_W'(rd_data_q) : '0;
		end
		if (cmd.out_load) begin
			page_out_q <= res_page_q;
			status_q   <= res_status_q;
			is_empty_q <= empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.take) begin
				head_q  <= head_next;
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.remove) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.kind     = kind_q;
	assign sts.full     = full;
	assign sts.empty    = empty;
	assign sts.hit      = (rd_data_q == key_q);
	assign sts.last     = (CNT_W'(idx_q) == count_q - CNT_W'(1));
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign page_out  = page_out_q;
	assign status    = status_q;
	assign is_empty  = is_empty_q;

endmodule

// ===== hw/rtl/page_fifo_with_removal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_fifo_with_removal: ordered page queue with remove by key
// Append, take and remove-first-match over a ring of DEPTH page entries.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; in_stall is high from the cycle after
// a beat is accepted until its result has been moved to the output register.
// A take waits for the registered read data of the single memory read port.
// A remove walks the ring one entry at a time (read, then compare) up to the
// first match, then moves each later entry down one slot (read, then write).
// A result waiting on out_stall holds the sequencer in its final state.
module page_fifo_with_removal #(
	parameter int DEPTH     = pfr_pkg::DEPTH_DEF,
	parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pfr_pkg::KIND_W-1:0]    kind,
	input  logic [pfr_pkg::PAGE_W-1:0]    page,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pfr_pkg::PAGE_W-1:0]    page_out,
	output logic [pfr_pkg::STATUS_W-1:0]  status,
	output logic                          is_empty
);
	import pfr_pkg::*;

	pfr_cmd_t cmd;
	pfr_sts_t sts;

	pfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfr_dp #(
		.DEPTH     (DEPTH),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind),
		.page      (page),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.page_out  (page_out),
		.status    (status),
		.is_empty  (is_empty)
	);

endmodule

// ===== sim/page_fifo_with_removal_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_fifo_with_removal_tb: self-checking bench for the page queue
// Drives append, take and remove beats through directed and random tests,
// keeps a shadow queue of pages to predict each result and compares every
// result beat field by field, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module page_fifo_with_removal_tb;
	import pfr_pkg::*;

	localparam int QUEUE_DEPTH = DEPTH_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 80;

	typedef struct packed {
		logic [PAGE_W-1:0] page_out;
		status_t           status;
		logic              is_empty;
	} page_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [KIND_W-1:0]   kind;
	logic [PAGE_W-1:0]   page;
	logic                out_valid;
	logic                out_stall;
	logic [PAGE_W-1:0]   page_out;
	logic [STATUS_W-1:0] status;
	logic                is_empty;

	page_fifo_with_removal dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.page      (page),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.page_out  (page_out),
		.status    (status),
		.is_empty  (is_empty)
	);

	logic [PAGE_W-1:0] shadow_pages[$];
	page_result_t      expected_results[$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int mismatch_count;
	int ops_sent;
	int results_checked;
	int peak_occupancy;
	int status_seen[4];
	int quiet_cycles;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// shadow queue update for one accepted beat
	task automatic predict_op(input kind_t k, input logic [PAGE_W-1:0] pg);
		page_result_t r;
		int hit;
		r.page_out = '0;
		r.status   = ST_OK;
		hit        = -1;
		case (k)
			KIND_APPEND: begin
				if (shadow_pages.size() >= QUEUE_DEPTH)
					r.status = ST_FULL;
				else
					shadow_pages.push_back(pg);
			end
			KIND_TAKE: begin
				if (shadow_pages.size() == 0)
					r.status = ST_EMPTY;
				else
					r.page_out = shadow_pages.pop_front();
			end
			KIND_REMOVE: begin
				for (int i = 0; i < shadow_pages.size(); i++) begin
					if (hit < 0 && shadow_pages[i] == pg)
						hit = i;
				end
				if (hit < 0)
					r.status = ST_NOT_FOUND;
				else
					shadow_pages.delete(hit);
			end
			default: ;
		endcase
		r.is_empty = (shadow_pages.size() == 0);
		if (shadow_pages.size() > peak_occupancy)
			peak_occupancy = shadow_pages.size();
		status_seen[r.status]++;
		expected_results.push_back(r);
	endtask

	task automatic send_beat(input kind_t k, input logic [PAGE_W-1:0] pg);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		kind     <= k;
		page     <= pg;
		do @(posedge clk); while (in_stall);
		predict_op(k, pg);
		ops_sent++;
	endtask

	// stop sending and wait until every result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		sender_idle_pct    = send_pct;
		receiver_stall_pct = stall_pct;
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, field, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		page_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result beat", {12'd0, page_out}, 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (page_out !== want.page_out)
					report_mismatch("page_out", {12'd0, page_out}, {12'd0, want.page_out});
				if (status !== want.status)
					report_mismatch("status", {30'd0, status}, {30'd0, want.status});
				if (is_empty !== want.is_empty)
					report_mismatch("is_empty", {31'd0, is_empty}, {31'd0, want.is_empty});
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("** page_fifo_with_removal: FAILED **");
			$finish;
		end
	end

	function automatic logic [PAGE_W-1:0] random_page();
		int pick;
		pick = $urandom_range(9);
		if (pick < 3)
			return PAGE_W'($urandom_range(3)) | 20'h5a5a0;
		if (pick == 3)
			return $urandom_range(1) ? '1 : '0;
		return PAGE_W'($urandom());
	endfunction

	// take, remove and the unused kind on an empty queue
	task automatic test_empty_queue();
		send_beat(KIND_TAKE, 20'hfffff);
		send_beat(KIND_REMOVE, 20'h00000);
		send_beat(KIND_NONE, 20'hfffff);
		drain_results();
	endtask

	// fill with extremes and duplicates, overflow, then remove and take
	task automatic test_full_queue();
		send_beat(KIND_APPEND, 20'h00000);
		send_beat(KIND_APPEND, 20'hfffff);
		send_beat(KIND_APPEND, 20'h00abc);
		send_beat(KIND_APPEND, 20'hfffff);
		for (int i = 4; i < QUEUE_DEPTH; i++)
			send_beat(KIND_APPEND, PAGE_W'($urandom()));
		send_beat(KIND_APPEND, 20'h12345);
		// only the duplicate nearest the head goes
		send_beat(KIND_REMOVE, 20'hfffff);
		send_beat(KIND_REMOVE, 20'h12345);
		send_beat(KIND_NONE, 20'h00000);
		send_beat(KIND_TAKE, 20'h00000);
		drain_results();
	endtask

	// alternate fill-heavy and drain-heavy bursts so full and empty are both hit
	task automatic test_random_traffic(input int num_ops);
		int roll;
		bit filling;
		kind_t k;
		logic [PAGE_W-1:0] pg;
		filling = 1'b1;
		for (int n = 0; n < num_ops; n++) begin
			if (n % 25 == 0)
				filling = (shadow_pages.size() < QUEUE_DEPTH / 2);
			roll = $urandom_range(99);
			if (roll < 4)
				k = KIND_NONE;
			else if (roll < (filling ? 70 : 24))
				k = KIND_APPEND;
			else if (roll < (filling ? 82 : 62))
				k = KIND_TAKE;
			else
				k = KIND_REMOVE;
			pg = random_page();
			if (k == KIND_REMOVE && shadow_pages.size() != 0 && $urandom_range(99) < 75)
				pg = shadow_pages[$urandom_range(shadow_pages.size() - 1)];
			send_beat(k, pg);
		end
		drain_results();
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		kind               = KIND_APPEND;
		page               = '0;
		out_stall          = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		mismatch_count     = 0;
		ops_sent           = 0;
		results_checked    = 0;
		peak_occupancy     = 0;
		quiet_cycles       = 0;
		for (int i = 0; i < 4; i++)
			status_seen[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0);
		test_empty_queue();
		test_full_queue();
		test_random_traffic(95);
		set_idling(71, 0);
		test_random_traffic(95);
		set_idling(0, 71);
		test_random_traffic(95);
		set_idling(13, 13);
		test_random_traffic(95);

		set_idling(0, 0);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never returned", expected_results.size(), 0);

		$display("ran %0d operations, checked %0d results, peak occupancy %0d of %0d",
			ops_sent, results_checked, peak_occupancy, QUEUE_DEPTH);
		$display("status mix: ok %0d, empty take %0d, not found %0d, full append %0d",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
			status_seen[ST_FULL]);
		if (mismatch_count == 0)
			$display("** page_fifo_with_removal: PASSED **");
		else
			$display("** page_fifo_with_removal: FAILED **");
		$finish;
	end

endmodule
